### hw/rtl/psrg_pkg.sv
`default_nettype none

package psrg_pkg;

    // Field widths of the bin and result requests.
    localparam int TRAIN_W = 8;
    localparam int RATE_W  = 17;
    localparam int DRAW_W  = 16;
    localparam int CFG_W   = 10;

    // Entries in the queue between the classifying front and the counting back.
    localparam int QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

### hw/rtl/psrg_if.sv
`default_nettype none

interface psrg_in_if
    import psrg_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [TRAIN_W-1:0] train_index;
    logic               first_bin;
    logic [RATE_W-1:0]  rate_q16;
    logic [DRAW_W-1:0]  spike_draw;
    logic [DRAW_W-1:0]  refrac_draw;

    modport source (
        output valid, train_index, first_bin, rate_q16, spike_draw, refrac_draw,
        input  ready
    );
    modport sink (
        input  valid, train_index, first_bin, rate_q16, spike_draw, refrac_draw,
        output ready
    );
endinterface

interface psrg_out_if
    import psrg_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [TRAIN_W-1:0] train_out;
    logic               spike;
    logic               in_refractory;

    modport source (
        output valid, train_out, spike, in_refractory,
        input  ready
    );
    modport sink (
        input  valid, train_out, spike, in_refractory,
        output ready
    );
endinterface

`default_nettype wire

### hw/rtl/psrg_front.sv
`default_nettype none

module psrg_front
    import psrg_pkg::*;
#(
    parameter int NUM_TRAINS     = 256,
    parameter int PROB_FRAC_BITS = 16,
    parameter int REFRAC_BITS    = 10,
    parameter int SLOT_W         = 8,
    parameter int ENTRY_W        = 36
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wen,
    input  wire logic [CFG_W-1:0]   cfg_wdata,
    psrg_in_if.sink                 bin_in,
    input  wire logic               queue_full,
    input  wire logic               clear_busy,
    output logic                    push,
    output logic [ENTRY_W-1:0]      push_data
);

    localparam int CNT_W  = REFRAC_BITS + 1;
    localparam int LHS_W  = RATE_W + DRAW_W;
    localparam int RHS_W  = DRAW_W + 1 + PROB_FRAC_BITS;
    localparam int CMP_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;
    localparam int PROD_W = DRAW_W + 1 + REFRAC_BITS;

    logic [CFG_W-1:0]       cfg_reg;
    logic [SLOT_W-1:0]      slot;
    logic [CMP_W-1:0]       prob_one;
    logic [CMP_W-1:0]       rate_ext;
    logic [CMP_W-1:0]       prob;
    logic [CMP_W-1:0]       lhs;
    logic [CMP_W-1:0]       rhs;
    logic                   fire;
    logic [REFRAC_BITS-1:0] dead_base;
    logic [PROD_W-1:0]      prod;
    logic [CNT_W-1:0]       dead;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wen)
        begin
            cfg_reg <= cfg_wdata;
        end
    end

    // Trains beyond the state depth fold back onto it; for fewer than 256
    // trains the fold is a constant table over the 8-bit index.
    generate
        if (NUM_TRAINS >= 256)
        begin : g_direct
            assign slot = SLOT_W'(bin_in.train_index);
        end
        else
        begin : g_fold
            logic [SLOT_W-1:0] slot_lut [256];
            for (genvar i = 0; i < 256; i++)
            begin : g_lut
                assign slot_lut[i] = SLOT_W'(i % NUM_TRAINS);
            end
            assign slot = slot_lut[bin_in.train_index];
        end
    endgenerate

    // Spike test p > (d+1)/2^16, cross-multiplied so that no rounding enters.
    always_comb
    begin
        prob_one = CMP_W'(1) << PROB_FRAC_BITS;
        rate_ext = CMP_W'(bin_in.rate_q16);
        prob     = (rate_ext > prob_one) ? prob_one : rate_ext;
        lhs      = prob << DRAW_W;
        rhs      = (CMP_W'(bin_in.spike_draw) + CMP_W'(1)) << PROB_FRAC_BITS;
        fire     = lhs > rhs;
    end

    always_comb
    begin
        dead_base = REFRAC_BITS'(cfg_reg);
        prod      = (PROD_W'(bin_in.refrac_draw) + PROD_W'(1)) * PROD_W'(dead_base);
        dead      = CNT_W'(dead_base) + prod[PROD_W-1:DRAW_W];
    end

    assign bin_in.ready = !queue_full && !clear_busy;
    assign push         = bin_in.valid && bin_in.ready;
    assign push_data    = {bin_in.train_index, slot, bin_in.first_bin, fire, dead};

endmodule

`default_nettype wire

### hw/rtl/psrg_queue.sv
`default_nettype none

module psrg_queue
    import psrg_pkg::*;
#(
    parameter int WIDTH = 36,
    parameter int DEPTH = 2
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  pop_valid,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]   entries_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full      = (count_reg == COUNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entries_reg[rd_ptr_reg];

endmodule

`default_nettype wire

### hw/rtl/psrg_back.sv
`default_nettype none

module psrg_back
    import psrg_pkg::*;
#(
    parameter int NUM_TRAINS  = 256,
    parameter int REFRAC_BITS = 10,
    parameter int SLOT_W      = 8,
    parameter int ENTRY_W     = 36
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               queue_valid,
    input  wire logic [ENTRY_W-1:0] queue_data,
    output logic                    pop,
    output logic                    clear_busy,
    psrg_out_if.source              bin_out
);

    localparam int CNT_W = REFRAC_BITS + 1;

    // Fields of the request at the head of the queue.
    logic [TRAIN_W-1:0] q_train;
    logic [SLOT_W-1:0]  q_slot;
    logic               q_first;
    logic               q_fire;
    logic [CNT_W-1:0]   q_dead;

    logic [CNT_W-1:0]   count_mem [NUM_TRAINS];
    logic [CNT_W-1:0]   mem_rd_reg;
    logic               fwd_hit_reg;
    logic [CNT_W-1:0]   fwd_val_reg;

    logic               clear_busy_reg;
    logic [SLOT_W-1:0]  clear_addr_reg;

    logic               b1_valid_reg;
    logic [TRAIN_W-1:0] b1_train_reg;
    logic [SLOT_W-1:0]  b1_slot_reg;
    logic               b1_first_reg;
    logic               b1_fire_reg;
    logic [CNT_W-1:0]   b1_dead_reg;

    logic               out_valid_reg;
    logic [TRAIN_W-1:0] out_train_reg;
    logic               out_spike_reg;
    logic               out_refr_reg;

    logic               commit;
    logic               b1_load;
    logic [CNT_W-1:0]   stored;
    logic [CNT_W-1:0]   cnt;
    logic               refr;
    logic               spike;
    logic [CNT_W-1:0]   new_cnt;
    logic               mem_we;
    logic [SLOT_W-1:0]  mem_wa;
    logic [CNT_W-1:0]   mem_wd;

    assign {q_train, q_slot, q_first, q_fire, q_dead} = queue_data;

    assign commit  = b1_valid_reg && (!out_valid_reg || bin_out.ready);
    assign b1_load = queue_valid && !clear_busy_reg && (!b1_valid_reg || commit);
    assign pop     = b1_load;

    // A countdown written by the committing request while the next one reads
    // the same train comes from the forward path, not from the stale read.
    always_comb
    begin
        stored  = fwd_hit_reg ? fwd_val_reg : mem_rd_reg;
        cnt     = b1_first_reg ? '0 : stored;
        refr    = (cnt != '0);
        spike   = !refr && b1_fire_reg;
        new_cnt = refr ? (cnt - CNT_W'(1)) : (b1_fire_reg ? b1_dead_reg : '0);
    end

    always_comb
    begin
        mem_we = commit || clear_busy_reg;
        mem_wa = clear_busy_reg ? clear_addr_reg : b1_slot_reg;
        mem_wd = clear_busy_reg ? '0 : new_cnt;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            count_mem[mem_wa] <= mem_wd;
        end
        if (b1_load)
        begin
            mem_rd_reg <= count_mem[q_slot];
        end
    end

    always_ff @(posedge clk)
    begin
        if (b1_load)
        begin
            fwd_hit_reg  <= commit && (b1_slot_reg == q_slot);
            fwd_val_reg  <= new_cnt;
            b1_train_reg <= q_train;
            b1_slot_reg  <= q_slot;
            b1_first_reg <= q_first;
            b1_fire_reg  <= q_fire;
            b1_dead_reg  <= q_dead;
        end
        if (commit)
        begin
            out_train_reg <= b1_train_reg;
            out_spike_reg <= spike;
            out_refr_reg  <= refr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
            b1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (clear_busy_reg)
            begin
                if (clear_addr_reg == SLOT_W'(NUM_TRAINS - 1))
                begin
                    clear_busy_reg <= 1'b0;
                end
                else
                begin
                    clear_addr_reg <= clear_addr_reg + SLOT_W'(1);
                end
            end
            if (b1_load)
            begin
                b1_valid_reg <= 1'b1;
            end
            else if (commit)
            begin
                b1_valid_reg <= 1'b0;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (bin_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign clear_busy            = clear_busy_reg;
    assign bin_out.valid         = out_valid_reg;
    assign bin_out.train_out     = out_train_reg;
    assign bin_out.spike         = out_spike_reg;
    assign bin_out.in_refractory = out_refr_reg;

endmodule

`default_nettype wire

### hw/rtl/poisson_spike_refractory_gen_core.sv
// Path: an accepted bin request passes the queue, working stage and output register;
// a stalled result side holds it. Throughput: one bin per cycle while results are
// taken, sustained through the per-train countdown memory, a read-modify-write with
// one read and one write each cycle and a forward between neighbouring bins.
// Reset: asynchronous, active low; the dead-time register returns to 0 and a clearing
// pass then zeroes the countdown memory, entry by entry, with input ready low.
`default_nettype none

module poisson_spike_refractory_gen_core
    import psrg_pkg::*;
#(
    parameter int NUM_TRAINS     = 256,
    parameter int PROB_FRAC_BITS = 16,
    parameter int REFRAC_BITS    = 10
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wen,
    input  wire logic [CFG_W-1:0] cfg_wdata,
    psrg_in_if.sink               bin_in,
    psrg_out_if.source            bin_out
);

    localparam int SLOT_W  = (NUM_TRAINS > 1) ? $clog2(NUM_TRAINS) : 1;
    localparam int CNT_W   = REFRAC_BITS + 1;
    localparam int ENTRY_W = TRAIN_W + SLOT_W + 2 + CNT_W;

    logic               push;
    logic [ENTRY_W-1:0] push_data;
    logic               queue_full;
    logic               pop;
    logic               queue_valid;
    logic [ENTRY_W-1:0] queue_data;
    logic               clear_busy;

    psrg_front #(
        .NUM_TRAINS     (NUM_TRAINS),
        .PROB_FRAC_BITS (PROB_FRAC_BITS),
        .REFRAC_BITS    (REFRAC_BITS),
        .SLOT_W         (SLOT_W),
        .ENTRY_W        (ENTRY_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .bin_in     (bin_in),
        .queue_full (queue_full),
        .clear_busy (clear_busy),
        .push       (push),
        .push_data  (push_data)
    );

    psrg_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_valid (queue_valid),
        .pop_data  (queue_data)
    );

    psrg_back #(
        .NUM_TRAINS  (NUM_TRAINS),
        .REFRAC_BITS (REFRAC_BITS),
        .SLOT_W      (SLOT_W),
        .ENTRY_W     (ENTRY_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_valid (queue_valid),
        .queue_data  (queue_data),
        .pop         (pop),
        .clear_busy  (clear_busy),
        .bin_out     (bin_out)
    );

endmodule

`default_nettype wire

### hw/rtl/psrg_checker.sv
`default_nettype none

module psrg_checker
    import psrg_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [TRAIN_W-1:0] train_out,
    input wire logic               spike,
    input wire logic               in_refractory
);

    // Queue, working stage and output register together hold four requests.
    localparam int CAPACITY = QUEUE_DEPTH + 2;
    localparam int FLIGHT_W = $clog2(CAPACITY + 2);

    logic                in_acc;
    logic                out_acc;
    logic [FLIGHT_W-1:0] flight_reg;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flight_reg <= '0;
        end
        else if (in_acc && !out_acc)
        begin
            flight_reg <= flight_reg + FLIGHT_W'(1);
        end
        else if (out_acc && !in_acc)
        begin
            flight_reg <= flight_reg - FLIGHT_W'(1);
        end
    end

    a_no_result_without_request: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (flight_reg != '0))
    else $error("result shown with no bin request outstanding");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        flight_reg <= FLIGHT_W'(CAPACITY))
    else $error("more bin requests outstanding than the block can hold");

    a_ready_low_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !in_ready)
    else $error("input ready before the countdown memory was cleared");

    a_spike_not_refractory: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(spike && in_refractory))
    else $error("spike reported inside a dead time");

    a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(train_out) && $stable(spike) && $stable(in_refractory)))
    else $error("stalled result changed");

endmodule

bind poisson_spike_refractory_gen_core psrg_checker u_psrg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (bin_in.valid),
    .in_ready      (bin_in.ready),
    .out_valid     (bin_out.valid),
    .out_ready     (bin_out.ready),
    .train_out     (bin_out.train_out),
    .spike         (bin_out.spike),
    .in_refractory (bin_out.in_refractory)
);

`default_nettype wire

### bench/poisson_spike_refractory_gen_core_test.sv
`timescale 1ns / 100ps

module poisson_spike_refractory_gen_core_test;
    import psrg_pkg::*;

    localparam int NUM_TRAINS     = 256;
    localparam int PROB_FRAC_BITS = 16;
    localparam int REFRAC_BITS    = 10;
    localparam int LONG_HOLD      = 200;
    localparam int PHASE_BINS     = 310;
    localparam int TIMEOUT_NS     = 10_000_000;

    typedef struct packed {
        logic [TRAIN_W-1:0] train;
        logic               first;
        logic [RATE_W-1:0]  rate;
        logic [DRAW_W-1:0]  sdraw;
        logic [DRAW_W-1:0]  rdraw;
    } bin_t;

    typedef struct packed {
        logic [TRAIN_W-1:0] train;
        logic               spike;
        logic               refr;
    } outcome_t;

    // Tracks the per-train dead time and holds the outcomes still owed by the block.
    class spike_train_tracker;
        logic [REFRAC_BITS:0] countdown [NUM_TRAINS];
        logic [CFG_W-1:0]     dead_bins;
        outcome_t             pending [$];
        int                   mismatches;
        int                   bins_seen;
        int                   spikes;
        int                   blocked;

        function new();
            foreach (countdown[i])
                countdown[i] = '0;
            dead_bins  = '0;
            mismatches = 0;
            bins_seen  = 0;
            spikes     = 0;
            blocked    = 0;
        endfunction

        function void set_dead_time(logic [CFG_W-1:0] value);
            dead_bins = value;
        endfunction

        function void note_bin(bin_t b);
            outcome_t    o;
            int          slot;
            logic [63:0] p;
            logic [63:0] r;
            logic [63:0] span;
            slot    = int'(b.train) % NUM_TRAINS;
            o.train = b.train;
            o.spike = 1'b0;
            o.refr  = 1'b0;
            if (b.first)
                countdown[slot] = '0;
            if (countdown[slot] != 0)
            begin
                o.refr = 1'b1;
                countdown[slot] = countdown[slot] - 1'b1;
            end
            else
            begin
                p = 64'(b.rate);
                if (p > (64'd1 << PROB_FRAC_BITS))
                    p = 64'd1 << PROB_FRAC_BITS;
                if ((p << DRAW_W) > ((64'(b.sdraw) + 64'd1) << PROB_FRAC_BITS))
                begin
                    o.spike = 1'b1;
                    r = 64'(dead_bins) & ((64'd1 << REFRAC_BITS) - 64'd1);
                    span = r + (((64'(b.rdraw) + 64'd1) * r) >> DRAW_W);
                    countdown[slot] = span[REFRAC_BITS:0];
                end
            end
            bins_seen++;
            if (o.spike)
                spikes++;
            if (o.refr)
                blocked++;
            pending.push_back(o);
        endfunction

        function void check_result(logic [TRAIN_W-1:0] train, logic spike, logic refr);
            outcome_t want;
            if (pending.size() == 0)
            begin
                $error("result for train %0d arrived with no bin outstanding", train);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            if (train !== want.train)
            begin
                $error("train_out: expected %0d, got %0d", want.train, train);
                mismatches++;
            end
            if (spike !== want.spike)
            begin
                $error("spike: expected %0d, got %0d", want.spike, spike);
                mismatches++;
            end
            if (refr !== want.refr)
            begin
                $error("in_refractory: expected %0d, got %0d", want.refr, refr);
                mismatches++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_wen;
    logic [CFG_W-1:0] cfg_wdata;
    logic             hold_request;
    logic             sink_calm;
    bit               source_calm;
    int               settings_used;
    int               drains;

    psrg_in_if  bin_req ();
    psrg_out_if bin_res ();

    spike_train_tracker tracker = new();

    poisson_spike_refractory_gen_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .bin_in    (bin_req),
        .bin_out   (bin_res)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("poisson_spike_refractory_gen_core_test NOT OK");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && bin_req.valid && bin_req.ready)
            tracker.note_bin({bin_req.train_index, bin_req.first_bin, bin_req.rate_q16,
                              bin_req.spike_draw, bin_req.refrac_draw});
        if (rst_n && bin_res.valid && bin_res.ready)
            tracker.check_result(bin_res.train_out, bin_res.spike, bin_res.in_refractory);
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: random back-pressure, plus one long hold-off on request.
    initial
    begin
        int gap;
        bin_res.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request  <= 1'b0;
                bin_res.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                bin_res.ready <= 1'b1;
            end
            else if (sink_calm)
                bin_res.ready <= 1'b1;
            else
            begin
                gap = pick_gap();
                if (gap == 0)
                    bin_res.ready <= 1'b1;
                else
                begin
                    bin_res.ready <= 1'b0;
                    repeat (gap - 1) @(posedge clk);
                end
            end
        end
    end

    function automatic bin_t make_bin(int train, bit first, int rate, int sdraw, int rdraw);
        bin_t b;
        b.train = TRAIN_W'(train);
        b.first = first;
        b.rate  = RATE_W'(rate);
        b.sdraw = DRAW_W'(sdraw);
        b.rdraw = DRAW_W'(rdraw);
        return b;
    endfunction

    // Most bins go to a few trains so that dead times are hit and neighbours share a train.
    function automatic bin_t rand_bin(int span, int first_pct);
        bin_t b;
        b.train = ($urandom_range(0, 9) == 0) ? TRAIN_W'($urandom_range(0, 255))
                                              : TRAIN_W'($urandom_range(0, span - 1));
        b.first = ($urandom_range(0, 99) < first_pct);
        b.sdraw = DRAW_W'($urandom_range(0, 65535));
        b.rdraw = DRAW_W'($urandom_range(0, 65535));
        case ($urandom_range(0, 9))
            0: b.rate = '0;
            1: b.rate = RATE_W'($urandom_range(65536, 131071));
            2: b.rate = RATE_W'(b.sdraw) + RATE_W'($urandom_range(0, 2));
            default: b.rate = RATE_W'($urandom_range(0, 65536));
        endcase
        return b;
    endfunction

    task automatic offer_bin(input bin_t b);
        bin_req.valid       <= 1'b1;
        bin_req.train_index <= b.train;
        bin_req.first_bin   <= b.first;
        bin_req.rate_q16    <= b.rate;
        bin_req.spike_draw  <= b.sdraw;
        bin_req.refrac_draw <= b.rdraw;
        do
            @(posedge clk);
        while (!bin_req.ready);
    endtask

    task automatic send_bin(input bin_t b);
        int gap;
        offer_bin(b);
        gap = source_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            bin_req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // The extra edge lets the monitor record a request accepted at the current one.
    task automatic drain_bins();
        bin_req.valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending.size() != 0)
            @(posedge clk);
        drains++;
    endtask

    task automatic write_dead_time(input logic [CFG_W-1:0] value);
        drain_bins();
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen <= 1'b0;
        tracker.set_dead_time(value);
        settings_used++;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] dead, input int count, input bit with_hold);
        int span;
        int first_pct;
        write_dead_time(dead);
        span      = (dead > 64) ? 4 : 8;
        first_pct = (dead > 64) ? 12 : 3;
        for (int i = 0; i < count; i++)
        begin
            if (i % 64 == 0)
            begin
                source_calm = ($urandom_range(0, 3) == 0);
                sink_calm  <= ($urandom_range(0, 3) == 0);
            end
            // Keep offering while the result side is held off, so the input stalls.
            if (with_hold && i == count / 2)
            begin
                hold_request <= 1'b1;
                repeat (40) offer_bin(rand_bin(span, first_pct));
            end
            if ($urandom_range(0, 99) == 0)
                drain_bins();
            send_bin(rand_bin(span, first_pct));
        end
    endtask

    initial
    begin
        bit failed;
        cfg_wen             = 1'b0;
        cfg_wdata           = '0;
        bin_req.valid       = 1'b0;
        bin_req.train_index = '0;
        bin_req.first_bin   = 1'b0;
        bin_req.rate_q16    = '0;
        bin_req.spike_draw  = '0;
        bin_req.refrac_draw = '0;
        hold_request        = 1'b0;
        sink_calm           = 1'b0;
        source_calm         = 1'b1;
        settings_used       = 0;
        drains              = 0;
        rst_n               = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Dead time zero after reset: probability edges and saturation.
        send_bin(make_bin(0, 1, 0, 0, 0));
        send_bin(make_bin(0, 0, 1, 0, 0));
        send_bin(make_bin(0, 0, 2, 0, 65535));
        send_bin(make_bin(0, 0, 65536, 65535, 0));
        send_bin(make_bin(0, 0, 65536, 65534, 65535));
        send_bin(make_bin(255, 1, 131071, 65535, 0));
        send_bin(make_bin(255, 0, 131071, 0, 65535));

        // Largest dead time: longest countdown, draws ignored, first bin clearing it.
        write_dead_time(10'd1023);
        send_bin(make_bin(1, 1, 131071, 0, 65535));
        send_bin(make_bin(1, 0, 131071, 0, 65535));
        send_bin(make_bin(1, 0, 65536, 0, 0));
        send_bin(make_bin(1, 1, 65536, 100, 0));
        send_bin(make_bin(2, 1, 0, 0, 0));
        send_bin(make_bin(1, 0, 131071, 0, 0));
        send_bin(make_bin(1, 1, 0, 65535, 65535));

        // Dead time one: countdowns of one and two.
        write_dead_time(10'd1);
        send_bin(make_bin(3, 1, 131071, 0, 0));
        send_bin(make_bin(3, 0, 131071, 0, 0));
        send_bin(make_bin(3, 0, 131071, 0, 65535));
        send_bin(make_bin(3, 0, 131071, 0, 0));
        send_bin(make_bin(3, 0, 131071, 0, 0));
        send_bin(make_bin(3, 0, 0, 0, 0));
        send_bin(make_bin(3, 1, 131071, 65535, 0));
        send_bin(make_bin(128, 1, 65535, 65533, 32767));

        run_phase(10'd0, PHASE_BINS, 1'b0);
        run_phase(CFG_W'($urandom_range(2, 30)), PHASE_BINS, 1'b1);
        run_phase(10'd1023, PHASE_BINS, 1'b0);
        run_phase(10'd1, PHASE_BINS, 1'b0);
        run_phase(CFG_W'($urandom_range(2, 30)), PHASE_BINS, 1'b0);
        run_phase(CFG_W'($urandom_range(0, 1023)), PHASE_BINS, 1'b0);

        drain_bins();
        repeat (8) @(posedge clk);

        if (tracker.pending.size() != 0)
        begin
            $error("%0d results never arrived", tracker.pending.size());
            tracker.mismatches++;
        end
        failed = (tracker.mismatches != 0);
        $display("Covered %0d bins with %0d spikes and %0d refractory bins over %0d dead-time settings.",
                 tracker.bins_seen, tracker.spikes, tracker.blocked, settings_used);
        $display("Included one long result hold-off and %0d full drains of the pipeline.", drains);
        if (!failed)
            $display("poisson_spike_refractory_gen_core_test OK");
        else
            $display("poisson_spike_refractory_gen_core_test NOT OK");
        $finish;
    end

endmodule
